@@ design/cgra_pkg.sv @@
// Shared types, widths and constants of the cylinder grid radius/angle block.
`default_nettype none
package cgra_pkg;

    localparam int IDX_W   = 10;
    localparam int STEP_W  = 16;
    localparam int CNT_W   = 11;
    localparam int COORD_W = 26;
    localparam int OFS_W   = 27;
    localparam int SQ_W    = 54;
    localparam int RSQ_W   = 53;
    localparam int ANG_W   = 15;
    localparam int ACC_W   = 17;
    localparam int CW      = 30;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam int ATAN_ENTRIES = 24;
    localparam int HALF_PI_Q14  = 25736;

    localparam logic [13:0] ATAN_Q14 [ATAN_ENTRIES] = '{
        14'd12868, 14'd7596, 14'd4014, 14'd2037, 14'd1023, 14'd512, 14'd256, 14'd128,
        14'd64,    14'd32,   14'd16,   14'd8,    14'd4,    14'd2,   14'd1,   14'd0,
        14'd0,     14'd0,    14'd0,    14'd0,    14'd0,    14'd0,   14'd0,   14'd0
    };

    typedef enum logic [2:0] {
        REG_STEP_X  = 3'd0,
        REG_STEP_Y  = 3'd1,
        REG_STEP_Z  = 3'd2,
        REG_COUNT_Y = 3'd3,
        REG_COUNT_Z = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        ANG_RUN,
        ANG_ZERO,
        ANG_HALF_PI
    } t_ang_sel;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } t_coords;

    typedef struct packed {
        logic               vld;
        t_coords            crd;
        logic [OFS_W-1:0]   dy;
        logic [OFS_W-1:0]   dz;
    } t_front;

endpackage
`default_nettype wire

@@ design/cgra_front.sv @@
// Front stages: centre offsets from the indices, then coordinate and offset products.
`default_nettype none
module cgra_front #(
    parameter int MAX_POINTS = 1024
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_vld,
    input  wire logic [cgra_pkg::IDX_W-1:0]  i_index_x,
    input  wire logic [cgra_pkg::IDX_W-1:0]  i_index_y,
    input  wire logic [cgra_pkg::IDX_W-1:0]  i_index_z,
    input  wire logic [cgra_pkg::STEP_W-1:0] i_step_x,
    input  wire logic [cgra_pkg::STEP_W-1:0] i_step_y,
    input  wire logic [cgra_pkg::STEP_W-1:0] i_step_z,
    input  wire logic [cgra_pkg::CNT_W-1:0]  i_count_y,
    input  wire logic [cgra_pkg::CNT_W-1:0]  i_count_z,
    output cgra_pkg::t_front                o_front
);
    import cgra_pkg::*;

    localparam logic [12:0] MaxP = 13'(MAX_POINTS);

    // Effective count minus one: zero acts as one, large counts clamp.
    function automatic logic [CNT_W-1:0] span_of(input logic [CNT_W-1:0] cnt);
        logic [12:0] wide;
        wide = {2'b00, cnt};
        if (cnt == '0) begin
            return '0;
        end else if (wide > MaxP) begin
            return CNT_W'(MAX_POINTS - 1);
        end else begin
            return cnt - CNT_W'(1);
        end
    endfunction

    // Magnitude of 2*index - span, exact in half steps.
    function automatic logic [CNT_W-1:0] mag_of(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] span);
        logic signed [12:0] d;
        d = $signed({2'b00, idx, 1'b0}) - $signed({2'b00, span});
        if (d < 0) begin
            return CNT_W'(-d);
        end else begin
            return CNT_W'(d);
        end
    endfunction

    logic                r_a_vld;
    logic [IDX_W-1:0]    r_ix, r_iy, r_iz;
    logic [CNT_W-1:0]    r_md_y, r_md_z;
    logic [CNT_W-1:0]    n_md_y, n_md_z;

    logic                r_b_vld;
    t_coords             r_crd;
    logic [OFS_W-1:0]    r_dy, r_dz;

    always_comb begin
        n_md_y = mag_of(i_index_y, span_of(i_count_y));
        n_md_z = mag_of(i_index_z, span_of(i_count_z));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ix   <= i_index_x;
        r_iy   <= i_index_y;
        r_iz   <= i_index_z;
        r_md_y <= n_md_y;
        r_md_z <= n_md_z;
        r_crd.x <= COORD_W'(r_ix) * COORD_W'(i_step_x);
        r_crd.y <= COORD_W'(r_iy) * COORD_W'(i_step_y);
        r_crd.z <= COORD_W'(r_iz) * COORD_W'(i_step_z);
        r_dy    <= OFS_W'(r_md_y) * OFS_W'(i_step_y);
        r_dz    <= OFS_W'(r_md_z) * OFS_W'(i_step_z);
    end

    assign o_front.vld = r_b_vld;
    assign o_front.crd = r_crd;
    assign o_front.dy  = r_dy;
    assign o_front.dz  = r_dz;

endmodule
`default_nettype wire

@@ design/cgra_radius.sv @@
// Squared radius with saturation, and a delay line that aligns it with the angle.
`default_nettype none
module cgra_radius #(
    parameter int DEPTH = 16
) (
    input  wire logic                       i_clk,
    input  wire cgra_pkg::t_front           i_front,
    output logic [cgra_pkg::RSQ_W-1:0]      o_rsq,
    output cgra_pkg::t_coords               o_crd
);
    import cgra_pkg::*;

    typedef struct packed {
        logic [RSQ_W-1:0] rsq;
        t_coords          crd;
    } t_rad_item;

    logic [SQ_W-1:0]  r_sy, r_sz;
    t_coords          r_crd;
    logic [SQ_W:0]    n_sum;
    t_rad_item        n_item;
    t_rad_item        r_line [DEPTH];

    always_comb begin
        n_sum = (SQ_W+1)'(r_sy) + (SQ_W+1)'(r_sz);
        n_item.crd = r_crd;
        if (n_sum[SQ_W:RSQ_W] != '0) begin
            n_item.rsq = '1;
        end else begin
            n_item.rsq = n_sum[RSQ_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sy  <= SQ_W'(i_front.dy) * SQ_W'(i_front.dy);
        r_sz  <= SQ_W'(i_front.dz) * SQ_W'(i_front.dz);
        r_crd <= i_front.crd;
        r_line[0] <= n_item;
        for (int k = 1; k < DEPTH; k++) begin
            r_line[k] <= r_line[k-1];
        end
    end

    assign o_rsq = r_line[DEPTH-1].rsq;
    assign o_crd = r_line[DEPTH-1].crd;

endmodule
`default_nettype wire

@@ design/cgra_cordic.sv @@
// Vectoring CORDIC pipeline, one micro-rotation per stage, then the angle clamp.
`default_nettype none
module cgra_cordic #(
    parameter int STEPS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_vld,
    input  wire logic [cgra_pkg::COORD_W-1:0] i_yc,
    input  wire logic [cgra_pkg::COORD_W-1:0] i_zc,
    output logic                             o_vld,
    output logic [cgra_pkg::ANG_W-1:0]       o_angle
);
    import cgra_pkg::*;

    localparam logic signed [ACC_W-1:0] HalfPi = ACC_W'(HALF_PI_Q14);

    logic signed [CW-1:0]    r_a   [STEPS];
    logic signed [CW-1:0]    r_b   [STEPS];
    logic signed [ACC_W-1:0] r_ang [STEPS];
    t_ang_sel                r_sel [STEPS];
    logic                    r_vld [STEPS];

    logic                    r_out_vld;
    logic [ANG_W-1:0]        r_out_ang;
    logic [ANG_W-1:0]        n_out_ang;

    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        logic signed [CW-1:0]    a_in, b_in;
        logic signed [ACC_W-1:0] ang_in;
        t_ang_sel                sel_in;
        logic                    vld_in;
        logic signed [CW-1:0]    n_a, n_b;
        logic signed [ACC_W-1:0] n_ang;
        logic signed [ACC_W-1:0] step_ang;

        if (k == 0) begin : g_first
            assign a_in   = $signed(CW'(i_yc));
            assign b_in   = $signed(CW'(i_zc));
            assign ang_in = '0;
            assign vld_in = i_vld;
            // A zero z gives zero, a zero y alone gives a quarter turn.
            always_comb begin
                priority if (i_zc == '0) begin
                    sel_in = ANG_ZERO;
                end else if (i_yc == '0) begin
                    sel_in = ANG_HALF_PI;
                end else begin
                    sel_in = ANG_RUN;
                end
            end
        end else begin : g_next
            assign a_in   = r_a[k-1];
            assign b_in   = r_b[k-1];
            assign ang_in = r_ang[k-1];
            assign sel_in = r_sel[k-1];
            assign vld_in = r_vld[k-1];
        end

        assign step_ang = $signed(ACC_W'(ATAN_Q14[k]));

        always_comb begin
            if (b_in >= 0) begin
                n_a   = a_in + (b_in >>> k);
                n_b   = b_in - (a_in >>> k);
                n_ang = ang_in + step_ang;
            end else begin
                n_a   = a_in - (b_in >>> k);
                n_b   = b_in + (a_in >>> k);
                n_ang = ang_in - step_ang;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_a[k]   <= n_a;
            r_b[k]   <= n_b;
            r_ang[k] <= n_ang;
            r_sel[k] <= sel_in;
        end
    end

    always_comb begin
        unique case (r_sel[STEPS-1])
            ANG_ZERO:    n_out_ang = '0;
            ANG_HALF_PI: n_out_ang = ANG_W'(HALF_PI_Q14);
            ANG_RUN: begin
                if (r_ang[STEPS-1] < 0) begin
                    n_out_ang = '0;
                end else if (r_ang[STEPS-1] > HalfPi) begin
                    n_out_ang = ANG_W'(HALF_PI_Q14);
                end else begin
                    n_out_ang = ANG_W'(r_ang[STEPS-1]);
                end
            end
            default:     n_out_ang = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld[STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_ang <= n_out_ang;
    end

    assign o_vld   = r_out_vld;
    assign o_angle = r_out_ang;

endmodule
`default_nettype wire

@@ design/cylinder_grid_radius_angle.sv @@
// Top level of the cylinder grid radius/angle block: register file and pipeline.
`default_nettype none
// Each request names one grid point by index_x, index_y and index_z. The block
// returns x, y and z as index times step (unsigned Q.8), the exact squared distance
// of (y,z) from the grid's y/z centre in units of 2^-18 (saturating at 2^53-1), and
// atan2(z, y) in Q1.14 radians from a vectoring CORDIC of CORDIC_STEPS rotations.
// A request is taken at every clock edge where start is high and busy is low, so a
// new point can enter in every cycle. busy is high only while reset is asserted.
// Each result appears on the o_ result ports for exactly one cycle with o_strobe
// high. Between request and result lie one register for the offsets, one for the
// products and one per CORDIC rotation, plus the final angle clamp. The squared
// radius and coordinates travel in a delay line beside the CORDIC. Results cannot
// be held off by the receiver, and none are dropped. Registers are written over
// the APB port; change them only while no request is in flight.
module cylinder_grid_radius_angle #(
    parameter int MAX_POINTS   = 1024,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Configuration port.
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [cgra_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [cgra_pkg::DATA_W-1:0]   pwdata,
    output logic      [cgra_pkg::DATA_W-1:0]   prdata,
    output logic                              pready,
    // Request side.
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [cgra_pkg::IDX_W-1:0]    i_index_x,
    input  wire logic [cgra_pkg::IDX_W-1:0]    i_index_y,
    input  wire logic [cgra_pkg::IDX_W-1:0]    i_index_z,
    // Result side.
    output logic                              o_strobe,
    output logic [cgra_pkg::COORD_W-1:0]       o_x_coord,
    output logic [cgra_pkg::COORD_W-1:0]       o_y_coord,
    output logic [cgra_pkg::COORD_W-1:0]       o_z_coord,
    output logic [cgra_pkg::RSQ_W-1:0]         o_radius_squared,
    output logic [cgra_pkg::ANG_W-1:0]         o_angle
);
    import cgra_pkg::*;

    logic [STEP_W-1:0] r_step_x, r_step_y, r_step_z;
    logic [CNT_W-1:0]  r_count_y, r_count_z;
    logic              wr_en;
    logic              accept;
    t_reg_idx          reg_idx;
    t_front            front;
    t_coords           crd_out;

    // Register file. The word address picks the register; byte offset bits are ignored.
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_x  <= STEP_W'(256);
            r_step_y  <= STEP_W'(256);
            r_step_z  <= STEP_W'(256);
            r_count_y <= CNT_W'(1);
            r_count_z <= CNT_W'(1);
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_STEP_X:  r_step_x  <= pwdata[STEP_W-1:0];
                REG_STEP_Y:  r_step_y  <= pwdata[STEP_W-1:0];
                REG_STEP_Z:  r_step_z  <= pwdata[STEP_W-1:0];
                REG_COUNT_Y: r_count_y <= pwdata[CNT_W-1:0];
                REG_COUNT_Z: r_count_z <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_STEP_X:  prdata = DATA_W'(r_step_x);
            REG_STEP_Y:  prdata = DATA_W'(r_step_y);
            REG_STEP_Z:  prdata = DATA_W'(r_step_z);
            REG_COUNT_Y: prdata = DATA_W'(r_count_y);
            REG_COUNT_Z: prdata = DATA_W'(r_count_z);
            default:     prdata = '0;
        endcase
    end

    // The pipeline never stalls, so requests are refused only during reset.
    assign busy   = ~i_rst_n;
    assign accept = start && !busy;

    cgra_front #(
        .MAX_POINTS(MAX_POINTS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (accept),
        .i_index_x (i_index_x),
        .i_index_y (i_index_y),
        .i_index_z (i_index_z),
        .i_step_x  (r_step_x),
        .i_step_y  (r_step_y),
        .i_step_z  (r_step_z),
        .i_count_y (r_count_y),
        .i_count_z (r_count_z),
        .o_front   (front)
    );

    // The radius path finishes early and waits in a delay line of one entry per
    // CORDIC rotation, so both reach the outputs in the same cycle.
    cgra_radius #(
        .DEPTH(CORDIC_STEPS)
    ) u_radius (
        .i_clk   (i_clk),
        .i_front (front),
        .o_rsq   (o_radius_squared),
        .o_crd   (crd_out)
    );

    cgra_cordic #(
        .STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (front.vld),
        .i_yc    (front.crd.y),
        .i_zc    (front.crd.z),
        .o_vld   (o_strobe),
        .o_angle (o_angle)
    );

    assign o_x_coord = crd_out.x;
    assign o_y_coord = crd_out.y;
    assign o_z_coord = crd_out.z;

endmodule
`default_nettype wire

@@ design/cgra_checker.sv @@
// Port-level checks of the cylinder grid radius/angle block, bound to its top level.
`default_nettype none
module cgra_checker #(
    parameter int LAT = 19
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         start,
    input wire logic                         busy,
    input wire logic                         o_strobe,
    input wire logic [cgra_pkg::COORD_W-1:0] o_y_coord,
    input wire logic [cgra_pkg::COORD_W-1:0] o_z_coord,
    input wire logic [cgra_pkg::ANG_W-1:0]   o_angle
);
    import cgra_pkg::*;

    a_req_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_strobe)
        else $error("accepted request produced no result after the pipeline latency");

    a_result_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT))
        else $error("result appeared without a matching request");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_angle <= ANG_W'(HALF_PI_Q14)))
        else $error("angle above a quarter turn");

    a_zero_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_z_coord == '0) |-> (o_angle == '0))
        else $error("zero z coordinate gave a nonzero angle");

    a_zero_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_y_coord == '0 && o_z_coord != '0) |->
            (o_angle == ANG_W'(HALF_PI_Q14)))
        else $error("zero y with nonzero z did not give a quarter turn");

endmodule

bind cylinder_grid_radius_angle cgra_checker #(
    .LAT(CORDIC_STEPS + 3)
) u_cgra_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .o_strobe  (o_strobe),
    .o_y_coord (o_y_coord),
    .o_z_coord (o_z_coord),
    .o_angle   (o_angle)
);
`default_nettype wire

@@ verif/cylinder_grid_radius_angle_test.sv @@
// Self-checking testbench of the cylinder grid radius/angle block.
module cylinder_grid_radius_angle_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cgra_pkg::*;

    // The block is built with its default sizes; the predictor uses the same values.
    localparam int GRID_LIMIT       = 1024;
    localparam int ROTATIONS        = 16;
    // Offsets, products, one stage per rotation, and the clamp.
    localparam int PIPE_DEPTH       = ROTATIONS + 3;
    localparam int PHASES           = 8;
    localparam int POINTS_PER_PHASE = 150;
    localparam int DIRECTED_ROWS    = 16;

    typedef longint unsigned t_u64;

    localparam t_u64 RSQ_CEIL = (t_u64'(1) << RSQ_W) - 1;

    // One result of the block, field by field.
    typedef struct packed {
        logic [COORD_W-1:0] x_coord;
        logic [COORD_W-1:0] y_coord;
        logic [COORD_W-1:0] z_coord;
        logic [RSQ_W-1:0]   radius_squared;
        logic [ANG_W-1:0]   angle;
    } t_grid_result;

    // One row of the directed table. Where typed is set, want holds the result
    // read straight off the specification; otherwise the predictor supplies it.
    typedef struct packed {
        logic [IDX_W-1:0] ix;
        logic [IDX_W-1:0] iy;
        logic [IDX_W-1:0] iz;
        logic             typed;
        t_grid_result     want;
    } t_directed_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                start = 1'b0;
    logic                busy;
    logic [IDX_W-1:0]    i_index_x = '0;
    logic [IDX_W-1:0]    i_index_y = '0;
    logic [IDX_W-1:0]    i_index_z = '0;
    logic                o_strobe;
    logic [COORD_W-1:0]  o_x_coord;
    logic [COORD_W-1:0]  o_y_coord;
    logic [COORD_W-1:0]  o_z_coord;
    logic [RSQ_W-1:0]    o_radius_squared;
    logic [ANG_W-1:0]    o_angle;

    // Shadow copy of the register file, kept in step with every APB write.
    logic [STEP_W-1:0]   cfg_step_x = 16'd256;
    logic [STEP_W-1:0]   cfg_step_y = 16'd256;
    logic [STEP_W-1:0]   cfg_step_z = 16'd256;
    logic [CNT_W-1:0]    cfg_count_y = 11'd1;
    logic [CNT_W-1:0]    cfg_count_z = 11'd1;

    // Results owed by the block, oldest first.
    t_grid_result        expected_points[$];
    int                  mismatches = 0;

    t_directed_row       directed_rows [DIRECTED_ROWS];

    cylinder_grid_radius_angle #(
        .MAX_POINTS  (GRID_LIMIT),
        .CORDIC_STEPS(ROTATIONS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .start           (start),
        .busy            (busy),
        .i_index_x       (i_index_x),
        .i_index_y       (i_index_y),
        .i_index_z       (i_index_z),
        .o_strobe        (o_strobe),
        .o_x_coord       (o_x_coord),
        .o_y_coord       (o_y_coord),
        .o_z_coord       (o_z_coord),
        .o_radius_squared(o_radius_squared),
        .o_angle         (o_angle)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Distance of one index from the grid centre along one axis, in units of
    // 2^-9: |2*index - (count-1)| * step. A count of zero acts as one, and a
    // count above the grid limit acts as the limit.
    function automatic t_u64 centre_offset(input logic [IDX_W-1:0] idx,
                                           input logic [CNT_W-1:0] count,
                                           input logic [STEP_W-1:0] step);
        longint span;
        longint d;
        if (count == '0) begin
            span = 1;
        end else if (count > GRID_LIMIT) begin
            span = GRID_LIMIT;
        end else begin
            span = longint'(count);
        end
        d = 2 * longint'(idx) - (span - 1);
        if (d < 0) begin
            d = -d;
        end
        return t_u64'(d) * t_u64'(step);
    endfunction

    // Vectoring CORDIC on the unshifted coordinates. A zero z gives zero and a
    // zero y with nonzero z gives a quarter turn; otherwise each rotation drives
    // z toward zero and the angle sum is clamped to the first quadrant.
    function automatic logic [ANG_W-1:0] cordic_angle_of(input t_u64 yc, input t_u64 zc);
        longint a;
        longint b;
        longint sa;
        longint sb;
        longint acc;
        if (zc == 0) begin
            return '0;
        end
        if (yc == 0) begin
            return ANG_W'(HALF_PI_Q14);
        end
        a = longint'(yc);
        b = longint'(zc);
        acc = 0;
        for (int i = 0; i < ROTATIONS && i < ATAN_ENTRIES; i++) begin
            sa = a >>> i;
            sb = b >>> i;
            if (b >= 0) begin
                a = a + sb;
                b = b - sa;
                acc = acc + longint'(ATAN_Q14[i]);
            end else begin
                a = a - sb;
                b = b + sa;
                acc = acc - longint'(ATAN_Q14[i]);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > HALF_PI_Q14) begin
            acc = HALF_PI_Q14;
        end
        return acc[ANG_W-1:0];
    endfunction

    // Full result of one grid point under the current register settings.
    function automatic t_grid_result predict_point(input logic [IDX_W-1:0] ix,
                                                   input logic [IDX_W-1:0] iy,
                                                   input logic [IDX_W-1:0] iz);
        t_grid_result r;
        t_u64 xc;
        t_u64 yc;
        t_u64 zc;
        t_u64 dy;
        t_u64 dz;
        t_u64 rsq;
        xc = t_u64'(ix) * t_u64'(cfg_step_x);
        yc = t_u64'(iy) * t_u64'(cfg_step_y);
        zc = t_u64'(iz) * t_u64'(cfg_step_z);
        dy = centre_offset(iy, cfg_count_y, cfg_step_y);
        dz = centre_offset(iz, cfg_count_z, cfg_step_z);
        rsq = dy * dy + dz * dz;
        if (rsq > RSQ_CEIL) begin
            rsq = RSQ_CEIL;
        end
        r.x_coord = xc[COORD_W-1:0];
        r.y_coord = yc[COORD_W-1:0];
        r.z_coord = zc[COORD_W-1:0];
        r.radius_squared = rsq[RSQ_W-1:0];
        r.angle = cordic_angle_of(yc, zc);
        return r;
    endfunction

    // Index with extra weight on both ends of the range.
    function automatic logic [IDX_W-1:0] pick_index();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return IDX_W'($urandom_range(0, 1023));
        endcase
    endfunction

    // APB write: setup cycle, then access cycles until pready. The shadow copy
    // keeps only the bits that the register holds.
    task automatic write_register(input t_reg_idx field_sel, input logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {field_sel, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (field_sel)
            REG_STEP_X:  cfg_step_x = value[STEP_W-1:0];
            REG_STEP_Y:  cfg_step_y = value[STEP_W-1:0];
            REG_STEP_Z:  cfg_step_z = value[STEP_W-1:0];
            REG_COUNT_Y: cfg_count_y = value[CNT_W-1:0];
            REG_COUNT_Z: cfg_count_z = value[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_grid(input logic [DATA_W-1:0] sx, input logic [DATA_W-1:0] sy,
                             input logic [DATA_W-1:0] sz, input logic [DATA_W-1:0] cy,
                             input logic [DATA_W-1:0] cz);
        write_register(REG_STEP_X, sx);
        write_register(REG_STEP_Y, sy);
        write_register(REG_STEP_Z, sz);
        write_register(REG_COUNT_Y, cy);
        write_register(REG_COUNT_Z, cz);
    endtask

    // Present one request and hold it until the block takes it. The expected
    // result is queued at the accepting edge, so it always sees the settings
    // that the block used.
    task automatic send_point(input logic [IDX_W-1:0] ix, input logic [IDX_W-1:0] iy,
                              input logic [IDX_W-1:0] iz, input logic typed,
                              input t_grid_result want);
        start <= 1'b1;
        i_index_x <= ix;
        i_index_y <= iy;
        i_index_z <= iz;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        if (typed) begin
            expected_points.push_back(want);
        end else begin
            expected_points.push_back(predict_point(ix, iy, iz));
        end
    endtask

    // The sender idles in each cycle with a chance of pct in a hundred. While
    // idle, the index inputs carry noise that must be ignored.
    task automatic sender_pause(input int pct);
        while ($urandom_range(0, 99) < pct) begin
            start <= 1'b0;
            i_index_x <= pick_index();
            i_index_y <= pick_index();
            i_index_z <= pick_index();
            @(posedge i_clk);
        end
    endtask

    // Every request yields exactly one result, so the block is idle once the
    // queue of expected results is empty.
    task automatic wait_drained();
        start <= 1'b0;
        while (expected_points.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Results are sampled mid-cycle, half a period away from the edges at which
    // the stimulus and the expected queue change.
    always @(negedge i_clk) begin : result_check
        t_grid_result want;
        if (o_strobe) begin
            if (expected_points.size() == 0) begin
                $error("result strobe with no request outstanding");
                mismatches++;
            end else begin
                want = expected_points.pop_front();
                if (o_x_coord !== want.x_coord) begin
                    $error("x_coord mismatch: expected %0d, got %0d", want.x_coord, o_x_coord);
                    mismatches++;
                end
                if (o_y_coord !== want.y_coord) begin
                    $error("y_coord mismatch: expected %0d, got %0d", want.y_coord, o_y_coord);
                    mismatches++;
                end
                if (o_z_coord !== want.z_coord) begin
                    $error("z_coord mismatch: expected %0d, got %0d", want.z_coord, o_z_coord);
                    mismatches++;
                end
                if (o_radius_squared !== want.radius_squared) begin
                    $error("radius_squared mismatch: expected %0d, got %0d",
                           want.radius_squared, o_radius_squared);
                    mismatches++;
                end
                if (o_angle !== want.angle) begin
                    $error("angle mismatch: expected %0d, got %0d", want.angle, o_angle);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        int pct;
        // Directed rows run with the reset settings: unit steps of 256 and counts
        // of one, so the centres sit at zero and each offset is twice the
        // coordinate. Rows on an axis have results that can be read off directly:
        // a zero z gives angle zero and a zero y with nonzero z gives a quarter
        // turn. The remaining rows cover the far corner, the diagonal and
        // alternating bit patterns, and are left to the predictor.
        directed_rows = '{
            '{10'd0,    10'd0,    10'd0,    1'b1, '{26'd0, 26'd0, 26'd0, 53'd0, 15'd0}},
            '{10'd1,    10'd0,    10'd0,    1'b1, '{26'd256, 26'd0, 26'd0, 53'd0, 15'd0}},
            '{10'd0,    10'd1,    10'd0,    1'b1, '{26'd0, 26'd256, 26'd0, 53'd262144, 15'd0}},
            '{10'd0,    10'd0,    10'd1,    1'b1,
              '{26'd0, 26'd0, 26'd256, 53'd262144, ANG_W'(HALF_PI_Q14)}},
            '{10'd1023, 10'd0,    10'd0,    1'b1, '{26'd261888, 26'd0, 26'd0, 53'd0, 15'd0}},
            '{10'd0,    10'd1023, 10'd0,    1'b1,
              '{26'd0, 26'd261888, 26'd0, 53'd274341298176, 15'd0}},
            '{10'd0,    10'd0,    10'd1023, 1'b1,
              '{26'd0, 26'd0, 26'd261888, 53'd274341298176, ANG_W'(HALF_PI_Q14)}},
            '{10'd1023, 10'd1023, 10'd1023, 1'b0, '0},
            '{10'd0,    10'd1,    10'd1,    1'b0, '0},
            '{10'd0,    10'd1023, 10'd1,    1'b0, '0},
            '{10'd0,    10'd1,    10'd1023, 1'b0, '0},
            '{10'd341,  10'd682,  10'd85,   1'b0, '0},
            '{10'd682,  10'd341,  10'd938,  1'b0, '0},
            '{10'd512,  10'd512,  10'd512,  1'b0, '0},
            '{10'd100,  10'd3,    10'd4,    1'b0, '0},
            '{10'd7,    10'd1000, 10'd999,  1'b0, '0}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n]) begin
            send_point(directed_rows[n].ix, directed_rows[n].iy, directed_rows[n].iz,
                       directed_rows[n].typed, directed_rows[n].want);
            sender_pause(12);
        end
        wait_drained();

        // Random phases, each under its own register settings. The sender idles
        // lightly in the first three, heavily in the next three, and not at all
        // in the last two.
        for (int ph = 0; ph < PHASES; ph++) begin
            pct = (ph < 3) ? 12 : (ph < 6) ? 79 : 0;
            case (ph)
                // Largest steps and a full grid: the coordinate maximum.
                0: load_grid(65535, 65535, 65535, 1024, 1024);
                // Zero steps collapse every point to the origin; a count of
                // zero acts as one.
                1: load_grid(0, 0, 0, 0, 0);
                // Counts above the grid limit act as the limit.
                2: load_grid(1, 1, 1, 2047, 2047);
                3: load_grid(256, 128, 512, 7, 1000);
                // Very flat and very steep angles.
                4: load_grid(65535, 1, 65535, 1, 1024);
                // Full-width random words: only the low bits may be kept.
                5: load_grid($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
                6: load_grid($urandom_range(0, 65535), $urandom_range(0, 65535),
                             $urandom_range(0, 65535), $urandom_range(1, 1024),
                             $urandom_range(1, 1024));
                default: load_grid(32768, 255, 32767, 512, 513);
            endcase
            for (int n = 0; n < POINTS_PER_PHASE; n++) begin
                send_point(pick_index(), pick_index(), pick_index(), 1'b0, '0);
                sender_pause(pct);
            end
            wait_drained();
        end

        // Watch a while longer for stray strobes.
        repeat (PIPE_DEPTH + 8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // A correct run finishes well before this limit, which ends the run as a failure.
    initial begin : watchdog
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
